// ----- rtl/segment_intersection_top_defines.svh -----
// assertion macros for the segment intersection block
// used by the checker; expects clk and rst in the scope of use
`ifndef SEGMENT_INTERSECTION_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TOP_DEFINES_SVH

// same-cycle implication
`define SI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// next-cycle implication
`define SI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

// ----- rtl/si_pkg.sv -----
// shared constants for the segment intersection block
// no dependencies
package si_pkg;

  localparam logic [1:0] OUT_HIT       = 2'd0;
  localparam logic [1:0] OUT_PARALLEL  = 2'd1;
  localparam logic [1:0] OUT_COLLINEAR = 2'd2;
  localparam logic [1:0] OUT_OUTSIDE   = 2'd3;

endpackage

// ----- rtl/si_if.sv -----
// valid/ready channel interfaces for segment pairs and results
// depends on nothing
interface si_in_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] other_start_x;
  logic signed [COORD_BITS-1:0] other_start_y;
  logic signed [COORD_BITS-1:0] other_end_x;
  logic signed [COORD_BITS-1:0] other_end_y;

  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  other_start_x, other_start_y, other_end_x, other_end_y, input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                other_start_x, other_start_y, other_end_x, other_end_y, output ready);
endinterface

interface si_out_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   outcome;
  logic signed [COORD_BITS-1:0] cross_x;
  logic signed [COORD_BITS-1:0] cross_y;

  modport source (output valid, outcome, cross_x, cross_y, input ready);
  modport sink (input valid, outcome, cross_x, cross_y, output ready);
endinterface

// ----- rtl/segment_intersection_top.sv -----
// segment intersection top level: cross products, scaling, division, rounding
// depends on si_pkg, si_if, si_cross, si_scale, si_div
//
// Exact 2D segment intersection on signed integer endpoints. One segment
// pair is taken every clock cycle unless the result side stalls, and one
// result word comes out for each, in order, after these stages: one stage
// for the differences, COORD_BITS+1 shift-and-add stages for the cross
// products, one decision stage, COORD_BITS+1 stages scaling nume_a by the
// first direction, one divider load stage, COORD_BITS+1 restoring divider
// stages and the output register. A stall on the result side holds the whole
// pipeline; input ready is low only while a result is waiting and not taken.
// Outcome 0 gives the crossing point truncated toward zero; parallel,
// collinear and outside give zeros.
module segment_intersection_top
  import si_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input logic     clk,
  input logic     rst,
  si_in_if.sink   req,
  si_out_if.source rsp
);

  localparam int D  = COORD_BITS + 1;
  localparam int PW = 2 * D + 1;
  localparam int NW = PW + D;
  localparam int VW = COORD_BITS + 3;
  localparam int TXB = COORD_BITS + 3;
  localparam int TYB = COORD_BITS + 1;

  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  logic                         c_valid;
  logic signed [PW-1:0]         c_den, c_na, c_nb;
  logic signed [COORD_BITS-1:0] c_ax, c_ay;
  logic signed [D-1:0]          c_d1x, c_d1y;

  si_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(req.valid),
    .ax(req.first_start_x), .ay(req.first_start_y),
    .bx(req.first_end_x), .by(req.first_end_y),
    .cx(req.other_start_x), .cy(req.other_start_y),
    .ex(req.other_end_x), .ey(req.other_end_y),
    .out_valid(c_valid), .denom(c_den), .nume_a(c_na), .nume_b(c_nb),
    .ax_out(c_ax), .ay_out(c_ay), .d1x_out(c_d1x), .d1y_out(c_d1y)
  );

  logic                         s_valid;
  logic [NW-1:0]                s_nx, s_ny;
  logic [PW-1:0]                s_den;
  logic                         s_negx, s_negy;
  logic [1:0]                   s_outcome;
  logic signed [COORD_BITS-1:0] s_ax, s_ay;

  si_scale #(.COORD_BITS(COORD_BITS)) u_scale (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(c_valid),
    .denom(c_den), .nume_a(c_na), .nume_b(c_nb),
    .ax(c_ax), .ay(c_ay), .d1x(c_d1x), .d1y(c_d1y),
    .out_valid(s_valid), .num_x(s_nx), .num_y(s_ny), .mag_den_out(s_den),
    .neg_x_out(s_negx), .neg_y_out(s_negy), .outcome_out(s_outcome),
    .ax_out(s_ax), .ay_out(s_ay)
  );

  logic                 dx_valid, dy_valid;
  logic [D-1:0]         qx, qy;
  logic                 rx_nz, ry_nz;
  logic [TXB-1:0]       tx;
  logic [TYB-1:0]       ty;

  si_div #(.COORD_BITS(COORD_BITS), .TAG_BITS(TXB)) u_div_x (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_valid),
    .num(s_nx), .den(s_den), .tag({s_outcome, s_negx, s_ax}),
    .out_valid(dx_valid), .quot(qx), .rem_nz(rx_nz), .tag_out(tx)
  );

  si_div #(.COORD_BITS(COORD_BITS), .TAG_BITS(TYB)) u_div_y (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_valid),
    .num(s_ny), .den(s_den), .tag({s_negy, s_ay}),
    .out_valid(dy_valid), .quot(qy), .rem_nz(ry_nz), .tag_out(ty)
  );

  logic signed [VW-1:0]         vx, vy, fx, fy;
  logic [1:0]                   d_outcome;
  logic signed [COORD_BITS-1:0] d_ax, d_ay;
  logic                         d_negx, d_negy;

  assign {d_outcome, d_negx, d_ax} = tx;
  assign {d_negy, d_ay}            = ty;

  always_comb begin
    vx = d_negx ? $signed(VW'(d_ax)) - $signed({{(VW-D){1'b0}}, qx})
                : $signed(VW'(d_ax)) + $signed({{(VW-D){1'b0}}, qx});
    vy = d_negy ? $signed(VW'(d_ay)) - $signed({{(VW-D){1'b0}}, qy})
                : $signed(VW'(d_ay)) + $signed({{(VW-D){1'b0}}, qy});
    fx = vx;
    fy = vy;
    if (rx_nz && !d_negx && vx < 0) begin
      fx = vx + VW'(1);
    end else if (rx_nz && d_negx && vx > 0) begin
      fx = vx - VW'(1);
    end
    if (ry_nz && !d_negy && vy < 0) begin
      fy = vy + VW'(1);
    end else if (ry_nz && d_negy && vy > 0) begin
      fy = vy - VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= dx_valid && dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.outcome <= d_outcome;
      rsp.cross_x <= (d_outcome == OUT_HIT) ? fx[COORD_BITS-1:0] : '0;
      rsp.cross_y <= (d_outcome == OUT_HIT) ? fy[COORD_BITS-1:0] : '0;
    end
  end

endmodule

// ----- rtl/si_cross.sv -----
// cross-product pipeline: differences, then one multiplier bit per stage
// forms denom, nume_a and nume_b exactly; depends on nothing else
module si_cross #(
  parameter int COORD_BITS = 32,
  localparam int D  = COORD_BITS + 1,
  localparam int PW = 2 * D + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  output logic                         out_valid,
  output logic signed [PW-1:0]         denom,
  output logic signed [PW-1:0]         nume_a,
  output logic signed [PW-1:0]         nume_b,
  output logic signed [COORD_BITS-1:0] ax_out,
  output logic signed [COORD_BITS-1:0] ay_out,
  output logic signed [D-1:0]          d1x_out,
  output logic signed [D-1:0]          d1y_out
);

  function automatic logic signed [D-1:0] diff(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
    return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  function automatic logic signed [PW-1:0] ext(input logic signed [D-1:0] a);
    return $signed({{(PW-D){a[D-1]}}, a});
  endfunction

  logic                         valid [D+1];
  logic signed [D-1:0]          d1x [D+1];
  logic signed [D-1:0]          d1y [D+1];
  logic signed [D-1:0]          d2x [D+1];
  logic signed [D-1:0]          d2y [D+1];
  logic signed [D-1:0]          rx [D+1];
  logic signed [D-1:0]          ry [D+1];
  logic signed [COORD_BITS-1:0] sax [D+1];
  logic signed [COORD_BITS-1:0] say [D+1];
  logic signed [PW-1:0]         den [D+1];
  logic signed [PW-1:0]         na [D+1];
  logic signed [PW-1:0]         nb [D+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1x[0] <= diff(bx, ax);
      d1y[0] <= diff(by, ay);
      d2x[0] <= diff(ex, cx);
      d2y[0] <= diff(ey, cy);
      rx[0]  <= diff(ax, cx);
      ry[0]  <= diff(ay, cy);
      sax[0] <= ax;
      say[0] <= ay;
      den[0] <= '0;
      na[0]  <= '0;
      nb[0]  <= '0;
    end
  end

  for (genvar j = 1; j <= D; j++) begin : g_stage
    localparam int  K    = j - 1;
    localparam bit  LAST = (K == D - 1);
    logic signed [PW-1:0] p_den1, p_den2, p_na1, p_na2, p_nb1, p_nb2;

    always_comb begin
      p_den1 = d1x[j-1][K] ? (ext(d2y[j-1]) <<< K) : '0;
      p_den2 = d1y[j-1][K] ? (ext(d2x[j-1]) <<< K) : '0;
      p_na1  = ry[j-1][K]  ? (ext(d2x[j-1]) <<< K) : '0;
      p_na2  = rx[j-1][K]  ? (ext(d2y[j-1]) <<< K) : '0;
      p_nb1  = ry[j-1][K]  ? (ext(d1x[j-1]) <<< K) : '0;
      p_nb2  = rx[j-1][K]  ? (ext(d1y[j-1]) <<< K) : '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j] <= 1'b0;
      end else if (adv) begin
        valid[j] <= valid[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1x[j] <= d1x[j-1];
        d1y[j] <= d1y[j-1];
        d2x[j] <= d2x[j-1];
        d2y[j] <= d2y[j-1];
        rx[j]  <= rx[j-1];
        ry[j]  <= ry[j-1];
        sax[j] <= sax[j-1];
        say[j] <= say[j-1];
        // sign bit of the multiplier carries negative weight
        den[j] <= LAST ? den[j-1] - p_den1 + p_den2 : den[j-1] + p_den1 - p_den2;
        na[j]  <= LAST ? na[j-1] - p_na1 + p_na2 : na[j-1] + p_na1 - p_na2;
        nb[j]  <= LAST ? nb[j-1] - p_nb1 + p_nb2 : nb[j-1] + p_nb1 - p_nb2;
      end
    end
  end

  assign out_valid = valid[D];
  assign denom     = den[D];
  assign nume_a    = na[D];
  assign nume_b    = nb[D];
  assign ax_out    = sax[D];
  assign ay_out    = say[D];
  assign d1x_out   = d1x[D];
  assign d1y_out   = d1y[D];

endmodule

// ----- rtl/si_scale.sv -----
// outcome decision and magnitude scaling of nume_a by the first direction
// one multiplier bit per stage; depends on si_pkg
module si_scale
  import si_pkg::*;
#(
  parameter int COORD_BITS = 32,
  localparam int D  = COORD_BITS + 1,
  localparam int PW = 2 * D + 1,
  localparam int NW = PW + D
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic signed [PW-1:0]         denom,
  input  logic signed [PW-1:0]         nume_a,
  input  logic signed [PW-1:0]         nume_b,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [D-1:0]          d1x,
  input  logic signed [D-1:0]          d1y,
  output logic                         out_valid,
  output logic [NW-1:0]                num_x,
  output logic [NW-1:0]                num_y,
  output logic [PW-1:0]                mag_den_out,
  output logic                         neg_x_out,
  output logic                         neg_y_out,
  output logic [1:0]                   outcome_out,
  output logic signed [COORD_BITS-1:0] ax_out,
  output logic signed [COORD_BITS-1:0] ay_out
);

  function automatic logic in_unit(input logic signed [PW-1:0] n,
                                   input logic signed [PW-1:0] d);
    if (d < 0) begin
      return (n <= 0) && (d <= n);
    end
    return (n >= 0) && (n <= d);
  endfunction

  logic [1:0] outcome_c;

  always_comb begin
    if (denom == '0) begin
      outcome_c = (nume_a == '0 && nume_b == '0) ? OUT_COLLINEAR : OUT_PARALLEL;
    end else if (in_unit(nume_a, denom) && in_unit(nume_b, denom)) begin
      outcome_c = OUT_HIT;
    end else begin
      outcome_c = OUT_OUTSIDE;
    end
  end

  logic                         valid [D+1];
  logic [PW-1:0]                mag_na [D+1];
  logic [PW-1:0]                mag_den [D+1];
  logic [D-1:0]                 mag_dx [D+1];
  logic [D-1:0]                 mag_dy [D+1];
  logic                         neg_x [D+1];
  logic                         neg_y [D+1];
  logic [1:0]                   outcome [D+1];
  logic signed [COORD_BITS-1:0] sax [D+1];
  logic signed [COORD_BITS-1:0] say [D+1];
  logic [NW-1:0]                acc_x [D+1];
  logic [NW-1:0]                acc_y [D+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_na[0]  <= nume_a[PW-1] ? (~nume_a + 1'b1) : nume_a;
      mag_den[0] <= denom[PW-1] ? (~denom + 1'b1) : denom;
      mag_dx[0]  <= d1x[D-1] ? (~d1x + 1'b1) : d1x;
      mag_dy[0]  <= d1y[D-1] ? (~d1y + 1'b1) : d1y;
      neg_x[0]   <= nume_a[PW-1] ^ d1x[D-1] ^ denom[PW-1];
      neg_y[0]   <= nume_a[PW-1] ^ d1y[D-1] ^ denom[PW-1];
      outcome[0] <= outcome_c;
      sax[0]     <= ax;
      say[0]     <= ay;
      acc_x[0]   <= '0;
      acc_y[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= D; j++) begin : g_stage
    localparam int K = j - 1;
    logic [NW-1:0] part_x, part_y;

    always_comb begin
      part_x = mag_dx[j-1][K] ? ({{D{1'b0}}, mag_na[j-1]} << K) : '0;
      part_y = mag_dy[j-1][K] ? ({{D{1'b0}}, mag_na[j-1]} << K) : '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j] <= 1'b0;
      end else if (adv) begin
        valid[j] <= valid[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mag_na[j]  <= mag_na[j-1];
        mag_den[j] <= mag_den[j-1];
        mag_dx[j]  <= mag_dx[j-1];
        mag_dy[j]  <= mag_dy[j-1];
        neg_x[j]   <= neg_x[j-1];
        neg_y[j]   <= neg_y[j-1];
        outcome[j] <= outcome[j-1];
        sax[j]     <= sax[j-1];
        say[j]     <= say[j-1];
        acc_x[j]   <= acc_x[j-1] + part_x;
        acc_y[j]   <= acc_y[j-1] + part_y;
      end
    end
  end

  assign out_valid   = valid[D];
  assign num_x       = acc_x[D];
  assign num_y       = acc_y[D];
  assign mag_den_out = mag_den[D];
  assign neg_x_out   = neg_x[D];
  assign neg_y_out   = neg_y[D];
  assign outcome_out = outcome[D];
  assign ax_out      = sax[D];
  assign ay_out      = say[D];

endmodule

// ----- rtl/si_div.sv -----
// restoring divider, one quotient bit per stage, unsigned magnitudes
// carries a side tag along with each word; depends on nothing else
module si_div #(
  parameter int COORD_BITS = 32,
  parameter int TAG_BITS   = 1,
  localparam int D  = COORD_BITS + 1,
  localparam int PW = 2 * D + 1,
  localparam int NW = PW + D
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [NW-1:0]       num,
  input  logic [PW-1:0]       den,
  input  logic [TAG_BITS-1:0] tag,
  output logic                out_valid,
  output logic [D-1:0]        quot,
  output logic                rem_nz,
  output logic [TAG_BITS-1:0] tag_out
);

  logic                valid [D+1];
  logic [PW-1:0]       rem [D+1];
  logic [D-1:0]        low [D+1];
  logic [D-1:0]        q [D+1];
  logic [PW-1:0]       dv [D+1];
  logic [TAG_BITS-1:0] tg [D+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= num[NW-1:D];
      low[0] <= num[D-1:0];
      q[0]   <= '0;
      dv[0]  <= den;
      tg[0]  <= tag;
    end
  end

  for (genvar j = 1; j <= D; j++) begin : g_stage
    localparam int I = D - j;
    logic [PW:0] trial;
    logic        take;

    always_comb begin
      trial = {rem[j-1], low[j-1][I]};
      take  = trial >= {1'b0, dv[j-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j] <= 1'b0;
      end else if (adv) begin
        valid[j] <= valid[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j] <= take ? PW'(trial - {1'b0, dv[j-1]}) : trial[PW-1:0];
        low[j] <= low[j-1];
        q[j]   <= q[j-1] | (take ? (D'(1) << I) : '0);
        dv[j]  <= dv[j-1];
        tg[j]  <= tg[j-1];
      end
    end
  end

  assign out_valid = valid[D];
  assign quot      = q[D];
  assign rem_nz    = rem[D] != '0;
  assign tag_out   = tg[D];

endmodule

// ----- rtl/si_checker.sv -----
// port-level checks for the segment intersection block, bound to the top
// depends on si_pkg and segment_intersection_top_defines.svh
`include "segment_intersection_top_defines.svh"

module si_checker
  import si_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            outcome,
  input logic [COORD_BITS-1:0] cross_x,
  input logic [COORD_BITS-1:0] cross_y
);

  `SI_ASSERT_IMP(a_miss_zero, out_valid && outcome != OUT_HIT, cross_x == '0 && cross_y == '0)
  `SI_ASSERT_IMP(a_ready_free, !out_valid, in_ready)
  `SI_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready)
  `SI_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(cross_x) && $stable(cross_y))

endmodule

bind segment_intersection_top si_checker #(.COORD_BITS(COORD_BITS)) u_si_checker (
  .clk(clk), .rst(rst),
  .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .outcome(rsp.outcome), .cross_x(rsp.cross_x), .cross_y(rsp.cross_y)
);

// ----- test/tb_segment_intersection_top.sv -----
// testbench for segment_intersection_top: streams segment pairs, predicts each result
// depends on si_pkg, si_if and the segment_intersection_top rtl
module tb_segment_intersection_top;
  import si_pkg::*;

  localparam int CB = 32;
  localparam int LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, ex, ey;
  } seg_pair_t;
  typedef struct packed {
    logic [1:0] outcome;
    coord_t     x;
    coord_t     y;
  } crossing_t;

  logic clk;
  logic rst;
  si_in_if #(.COORD_BITS(CB)) req ();
  si_out_if #(.COORD_BITS(CB)) rsp ();

  segment_intersection_top #(.COORD_BITS(CB)) u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int errors;
  int cycle_count;
  int rx_gap;
  int tx_gap;
  int hold_count;
  bit stim_done;
  bit calm;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [255:0] d1x, d1y, d2x, d2y, rx, ry, den, na, nb, px, py;
    crossing_t r;
    bit ok_a, ok_b;
    d1x = 256'(p.bx) - 256'(p.ax);
    d1y = 256'(p.by) - 256'(p.ay);
    d2x = 256'(p.ex) - 256'(p.cx);
    d2y = 256'(p.ey) - 256'(p.cy);
    rx = 256'(p.ax) - 256'(p.cx);
    ry = 256'(p.ay) - 256'(p.cy);
    den = d2y * d1x - d2x * d1y;
    na = d2x * ry - d2y * rx;
    nb = d1x * ry - d1y * rx;
    r = '0;
    if (den == 0) begin
      r.outcome = (na == 0 && nb == 0) ? OUT_COLLINEAR : OUT_PARALLEL;
      return r;
    end
    if (den < 0) begin
      ok_a = (na <= 0) && (den <= na);
      ok_b = (nb <= 0) && (den <= nb);
    end else begin
      ok_a = (na >= 0) && (na <= den);
      ok_b = (nb >= 0) && (nb <= den);
    end
    if (!(ok_a && ok_b)) begin
      r.outcome = OUT_OUTSIDE;
      return r;
    end
    px = (256'(p.ax) * den + na * d1x) / den;
    py = (256'(p.ay) * den + na * d1y) / den;
    r.outcome = OUT_HIT;
    r.x = px[CB-1:0];
    r.y = py[CB-1:0];
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 200)) - 100;
      default: return coord_t'($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  task automatic queue_pair(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                            coord_t cx, coord_t cy, coord_t ex, coord_t ey);
    seg_pair_t p;
    p = '{ax, ay, bx, by, cx, cy, ex, ey};
    pending_pairs = {pending_pairs, p};
  endtask

  task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  initial begin
    seg_pair_t p;
    coord_t mx, mn;
    int mode;
    int k;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    // directed: hit, parallel, collinear, outside, endpoint touch, extremes
    queue_pair(0, 0, 10, 10, 0, 10, 10, 0);
    queue_pair(0, 0, 10, 0, 0, 5, 10, 5);
    queue_pair(0, 0, 10, 0, 20, 0, 30, 0);
    queue_pair(0, 0, 1, 1, 5, 0, 6, -1);
    queue_pair(0, 0, 10, 0, 10, 0, 10, 10);
    queue_pair(0, 0, 7, 3, 0, 3, 7, 0);
    queue_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    queue_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    queue_pair(mn, mn, mn, mn, mn, mn, mn, mn);
    queue_pair(mx, mx, mx, mx, mx, mx, mx, mx);
    queue_pair(-1, -1, -1, -1, 0, 0, 0, 0);
    queue_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    queue_pair(-5, -3, 4, 8, 6, -7, -2, 9);
    queue_pair(3, 3, 3, 3, 3, 3, 3, 3);
    queue_pair(mx, 0, mn, 0, 0, mx, 0, mn);
    queue_pair(-7, 2, 9, -3, -7, 2, 9, -3);
    for (k = 0; k < 1000; k++) begin
      mode = $urandom_range(0, 2);
      p.ax = rand_coord(mode); p.ay = rand_coord(mode);
      p.bx = rand_coord(mode); p.by = rand_coord(mode);
      p.cx = rand_coord(mode); p.cy = rand_coord(mode);
      p.ex = rand_coord(mode); p.ey = rand_coord(mode);
      if ($urandom_range(0, 9) == 0) begin
        p.cx = p.ax + (p.bx - p.ax) * 2; p.cy = p.ay + (p.by - p.ay) * 2;
        p.ex = p.ax - (p.bx - p.ax);     p.ey = p.ay - (p.by - p.ay);
      end else if ($urandom_range(0, 9) == 0) begin
        p.ex = p.cx + (p.bx - p.ax); p.ey = p.cy + (p.by - p.ay);
      end
      pending_pairs = {pending_pairs, p};
    end
  end

  // calm phase: last part of the run with no idling
  assign calm = (pending_pairs.size() < 150);
  assign hold_req = (hold_count > 300 && hold_count < 700);

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    {req.first_start_x, req.first_start_y, req.first_end_x, req.first_end_y} = '0;
    {req.other_start_x, req.other_start_y, req.other_end_x, req.other_end_y} = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // long receiver hold-off window
  always @(posedge clk) begin
    if (!rst) begin
      hold_count <= hold_count + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (!req.valid || req.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          req.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(0, 2);
          req.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          seg_pair_t p;
          p = pending_pairs.pop_front();
          expected_crossings = {expected_crossings, predict_crossing(p)};
          req.valid <= 1'b1;
          req.first_start_x <= p.ax; req.first_start_y <= p.ay;
          req.first_end_x <= p.bx;   req.first_end_y <= p.by;
          req.other_start_x <= p.cx; req.other_start_y <= p.cy;
          req.other_end_x <= p.ex;   req.other_end_y <= p.ey;
        end else begin
          req.valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        rsp.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 2);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_crossings.size() == 0) begin
        report_mismatch("unexpected word", '0, '0);
      end else begin
        crossing_t e;
        e = expected_crossings.pop_front();
        if (rsp.outcome !== e.outcome) report_mismatch("outcome", CB'(rsp.outcome), CB'(e.outcome));
        if (rsp.cross_x !== e.x) report_mismatch("cross_x", rsp.cross_x, e.x);
        if (rsp.cross_y !== e.y) report_mismatch("cross_y", rsp.cross_y, e.y);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("timeout with %0d results outstanding", expected_crossings.size());
        $display("Simulation FAILED");
        $finish;
      end
      if (stim_done && !req.valid && expected_crossings.size() == 0) begin
        repeat (3 * CB + 20) @(posedge clk);
        if (errors == 0) begin
          $display("Simulation PASSED");
        end else begin
          $display("Simulation FAILED");
        end
        $finish;
      end
    end
  end

endmodule
